FILE: hdl/hex_dump_line_formatter_macros.svh
// Assertion macros for the hex-dump line formatter.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef HEX_DUMP_LINE_FORMATTER_MACROS_SVH
`define HEX_DUMP_LINE_FORMATTER_MACROS_SVH
`ifndef SYNTHESIS
`define HDLF_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("hex dump formatter assertion failed");
`define HDLF_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("hex dump formatter assertion failed");
`else
`define HDLF_ASSERT_SAME(label, pre, post)
`define HDLF_ASSERT_NEXT(label, pre, post)
`endif
`endif

FILE: hdl/hdlf_pkg.sv
// Package for the hex-dump line formatter: payload types, command and status
// structs, character constants and character helper functions. No dependencies.
package hdlf_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_BAR   = 8'h7c;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] PRINT_LO = 8'h1f;
    localparam logic [7:0] PRINT_HI = 8'h7f;
    localparam logic [31:0] LINE_STEP = 32'd16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } out_item_t;

    typedef enum logic [2:0] {
        SEL_ADDR,
        SEL_SPACE,
        SEL_HI,
        SEL_LO,
        SEL_BAR,
        SEL_ASCII,
        SEL_NL
    } char_sel_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        char_sel_t sel;
        logic [2:0] nib;
        logic [3:0] idx;
        logic      run_last;
        logic      col_inc;
        logic      line_done;
    } cmd_t;

    typedef struct packed {
        logic [3:0] col;
        logic       last;
        logic       slot_free;
    } status_t;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10)
        begin
            c = CH_ZERO + {4'b0000, n};
        end
        else
        begin
            c = CH_LOW_A + {4'b0000, n} - 8'd10;
        end
        return c;
    endfunction

    function automatic logic [7:0] show_char(input logic [7:0] b);
        logic [7:0] c;
        if (b > PRINT_LO && b < PRINT_HI)
        begin
            c = b;
        end
        else
        begin
            c = CH_DOT;
        end
        return c;
    endfunction

endpackage

FILE: hdl/hex_dump_line_formatter.sv
// Top level of the hex-dump line formatter: joins controller and datapath.
// Depends on hdlf_pkg, hdlf_ctrl, hdlf_datapath and the assertion macro header.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   in_data   (data_byte, last_byte)
//   output   out_valid / out_ready out_data  (out_char, run_last)
//   config   cfg_we                cfg_wdata (start_address)
//
// Each request is accepted, then causes 3 to 64 characters, passed out through the
// single-character output register.
// Reset clears the column and loads line address zero; no clearing pass is run.
// A low out_ready holds the controller; the next request is accepted while the
// last character of the previous one still waits in the output register.
`include "hex_dump_line_formatter_macros.svh"

module hex_dump_line_formatter
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hdlf_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output hdlf_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata
);

    hdlf_pkg::cmd_t    cmd;
    hdlf_pkg::status_t status;

    hdlf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    hdlf_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `HDLF_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready)
    `HDLF_ASSERT_SAME(a_newline_ends, out_valid && out_data.out_char == hdlf_pkg::CH_NL, out_data.run_last)
    `HDLF_ASSERT_NEXT(a_line_resets_col, cmd.line_done, status.col == 4'd0)

endmodule

FILE: hdl/hdlf_ctrl.sv
// Controller of the hex-dump line formatter: sequences the characters of one request.
// Depends on hdlf_pkg for the command and status structs.
module hdlf_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hdlf_pkg::status_t status,
    output hdlf_pkg::cmd_t    cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ADDR  = 9'b000000010,
        S_SEP   = 9'b000000100,
        S_HEX   = 9'b000001000,
        S_PAD   = 9'b000010000,
        S_OPEN  = 9'b000100000,
        S_ASCII = 9'b001000000,
        S_CLOSE = 9'b010000000,
        S_NL    = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [3:0] idx_reg, idx_next;
    logic       close_line;
    logic       hex_gap;
    logic       pad_gap;

    assign close_line = (status.col == 4'd15) || status.last;
    assign hex_gap    = (status.col == 4'd7) || (status.col == 4'd15);
    assign pad_gap    = (idx_reg == 4'd7) || (idx_reg == 4'd15);
    assign in_ready   = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.sel      = hdlf_pkg::SEL_SPACE;
        cmd.nib      = 3'd7 - cnt_reg;
        cmd.idx      = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = 3'd0;
                    state_next = (status.col == 4'd0) ? S_ADDR : S_HEX;
                end
            end
            S_ADDR:
            begin
                cmd.sel = hdlf_pkg::SEL_ADDR;
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (cnt_reg == 3'd7)
                    begin
                        cnt_next   = 3'd0;
                        state_next = S_SEP;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
            end
            S_SEP:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (cnt_reg == 3'd1)
                    begin
                        cnt_next   = 3'd0;
                        state_next = S_HEX;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
            end
            S_HEX:
            begin
                if (cnt_reg == 3'd0)
                begin
                    cmd.sel = hdlf_pkg::SEL_HI;
                end
                else if (cnt_reg == 3'd1)
                begin
                    cmd.sel = hdlf_pkg::SEL_LO;
                end
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if ((cnt_reg == 3'd2 && !hex_gap) || cnt_reg == 3'd3)
                    begin
                        cnt_next = 3'd0;
                        if (!close_line)
                        begin
                            cmd.run_last = 1'b1;
                            cmd.col_inc  = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else if (status.col == 4'd15)
                        begin
                            state_next = S_OPEN;
                        end
                        else
                        begin
                            idx_next   = status.col + 4'd1;
                            state_next = S_PAD;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
            end
            S_PAD:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if ((cnt_reg == 3'd2 && !pad_gap) || cnt_reg == 3'd3)
                    begin
                        cnt_next = 3'd0;
                        if (idx_reg == 4'd15)
                        begin
                            state_next = S_OPEN;
                        end
                        else
                        begin
                            idx_next = idx_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
            end
            S_OPEN:
            begin
                cmd.sel = hdlf_pkg::SEL_BAR;
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    idx_next   = 4'd0;
                    state_next = S_ASCII;
                end
            end
            S_ASCII:
            begin
                cmd.sel = hdlf_pkg::SEL_ASCII;
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (idx_reg == status.col)
                    begin
                        state_next = S_CLOSE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            S_CLOSE:
            begin
                cmd.sel = hdlf_pkg::SEL_BAR;
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_NL;
                end
            end
            S_NL:
            begin
                cmd.sel = hdlf_pkg::SEL_NL;
                if (status.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.run_last  = 1'b1;
                    cmd.line_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 3'd0;
            idx_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

FILE: hdl/hdlf_datapath.sv
// Datapath of the hex-dump line formatter: byte and line registers, ASCII column
// store, character selection and the output register. Depends on hdlf_pkg.
module hdlf_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  hdlf_pkg::in_item_t  in_data,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    input  hdlf_pkg::cmd_t      cmd,
    output hdlf_pkg::status_t   status,
    output logic                out_valid,
    input  logic                out_ready,
    output hdlf_pkg::out_item_t out_data
);

    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [3:0]  col_reg, col_next;
    logic [31:0] line_addr_reg, line_addr_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_char_reg;
    logic        out_last_reg;
    logic [7:0]  store [16];
    logic [7:0]  char_next;

    always_comb
    begin
        case (cmd.sel)
            hdlf_pkg::SEL_ADDR:  char_next = hdlf_pkg::hex_char(line_addr_reg[{cmd.nib, 2'b00} +: 4]);
            hdlf_pkg::SEL_HI:    char_next = hdlf_pkg::hex_char(byte_reg[7:4]);
            hdlf_pkg::SEL_LO:    char_next = hdlf_pkg::hex_char(byte_reg[3:0]);
            hdlf_pkg::SEL_BAR:   char_next = hdlf_pkg::CH_BAR;
            hdlf_pkg::SEL_NL:    char_next = hdlf_pkg::CH_NL;
            default:             char_next = hdlf_pkg::CH_SPACE;
        endcase
    end

    always_comb
    begin
        col_next       = col_reg;
        line_addr_next = line_addr_reg;
        if (cmd.col_inc)
        begin
            col_next = col_reg + 4'd1;
        end
        if (cmd.line_done)
        begin
            col_next       = 4'd0;
            line_addr_next = line_addr_reg + hdlf_pkg::LINE_STEP;
        end
        if (cfg_we)
        begin
            line_addr_next = cfg_wdata;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= 4'd0;
            line_addr_reg <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            line_addr_reg <= line_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg       <= in_data.data_byte;
            last_reg       <= in_data.last_byte;
            store[col_reg] <= hdlf_pkg::show_char(in_data.data_byte);
        end
        if (cmd.emit)
        begin
            if (cmd.sel == hdlf_pkg::SEL_ASCII)
            begin
                out_char_reg <= store[cmd.idx];
            end
            else
            begin
                out_char_reg <= char_next;
            end
            out_last_reg <= cmd.run_last;
        end
    end

    assign status.col       = col_reg;
    assign status.last      = last_reg;
    assign status.slot_free = !out_valid_reg || out_ready;

    assign out_valid         = out_valid_reg;
    assign out_data.out_char = out_char_reg;
    assign out_data.run_last = out_last_reg;

endmodule
